// ----- rtl/core/bilateral_image_filter_top_assert.svh -----
// assertion macros for the bilateral filter top level
`ifndef BILATERAL_IMAGE_FILTER_TOP_ASSERT_SVH
`define BILATERAL_IMAGE_FILTER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BIF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bif_pkg.sv -----
`timescale 1ns / 1ps

package bif_pkg;

  typedef longint unsigned u64_t;

  // register indexes on the configuration port
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int CFG_W = 9;
  // window offsets cover radius up to 15
  localparam int OFS_W = 5;
  // accumulator widths sized for the largest window (31 x 31)
  localparam int NUM_W = 50;
  localparam int DEN_W = 42;
  localparam int REM_W = 51;

  // exp(-n) in Q30 for n = 0 .. 11
  localparam logic [31:0] EXP_INT_Q30 [12] = '{
    32'd1073741824, 32'd395007543, 32'd145315153, 32'd53458458,
    32'd19666268, 32'd7234816, 32'd2661539, 32'd979126,
    32'd360200, 32'd132510, 32'd48748, 32'd17933
  };

  // controller to datapath commands
  typedef struct packed {
    logic             in_take;
    logic             rd_centre;
    logic             acc_clear;
    logic             win_issue;
    logic             centre_load;
    logic [OFS_W-1:0] ofs_row;
    logic [OFS_W-1:0] ofs_col;
    logic             div_init;
    logic             div_step;
    logic [2:0]       div_bit;
    logic             out_load;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } sts_t;

  // division by a small literal, elaboration use only
  function automatic u64_t div_small(u64_t v, int d);
    u64_t r;
    unique case (d)
      1:  r = v;
      2:  r = v / 2;
      3:  r = v / 3;
      4:  r = v / 4;
      5:  r = v / 5;
      6:  r = v / 6;
      7:  r = v / 7;
      8:  r = v / 8;
      9:  r = v / 9;
      10: r = v / 10;
      11: r = v / 11;
      12: r = v / 12;
      13: r = v / 13;
      default: r = v;
    endcase
    return r;
  endfunction

  // 65536*exp(-x) with x in Q16, integer table times taylor series of the fraction
  function automatic logic [15:0] exp_weight(u64_t xq);
    u64_t   n;
    u64_t   f;
    u64_t   term;
    u64_t   w;
    longint acc;
    int     k;
    n    = xq >> 16;
    f    = xq & 64'hFFFF;
    term = 64'd1 << 30;
    acc  = 0;
    if (n >= 12) begin
      return 16'd0;
    end
    for (k = 0; k <= 12; k++) begin
      if (k[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
      term = div_small((term * f) >> 16, k + 1);
    end
    if (acc < 0) begin
      acc = 0;
    end
    w = (u64_t'(acc) * u64_t'(EXP_INT_Q30[n[3:0]]) + (64'd1 << 43)) >> 44;
    if (w > 64'd65535) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

endpackage

// ----- rtl/core/bif_ctrl.sv -----
`timescale 1ns / 1ps

module bif_ctrl #(
  parameter int RADIUS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          mode_i,
  output logic          in_stall_o,
  input  bif_pkg::sts_t sts_i,
  output bif_pkg::ctl_t ctl_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_WINDOW,
    ST_DRAIN,
    ST_DIV_INIT,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  localparam logic [bif_pkg::OFS_W-1:0] WIN_LAST = bif_pkg::OFS_W'(2 * RADIUS);

  state_e                      state_q, state_d;
  logic [bif_pkg::OFS_W-1:0]   row_q, row_d;
  logic [bif_pkg::OFS_W-1:0]   col_q, col_d;
  logic [2:0]                  bit_q, bit_d;
  logic                        take;

  assign in_stall_o = (state_q != ST_IDLE);
  assign take       = in_valid_i && (state_q == ST_IDLE);

  // next state and counters
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    bit_d   = bit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && mode_i) begin
          state_d = ST_CENTRE;
        end
      end
      ST_CENTRE: begin
        row_d   = '0;
        col_d   = '0;
        state_d = ST_WINDOW;
      end
      ST_WINDOW: begin
        if (col_q == WIN_LAST) begin
          col_d = '0;
          row_d = row_q + 1'b1;
          if (row_q == WIN_LAST) begin
            state_d = ST_DRAIN;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        bit_d   = 3'd7;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        bit_d = bit_q - 1'b1;
        if (bit_q == 3'd0) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands decoded from state
  always_comb begin
    ctl_o             = '0;
    ctl_o.in_take     = take;
    ctl_o.rd_centre   = (state_q == ST_CENTRE);
    ctl_o.acc_clear   = (state_q == ST_CENTRE);
    ctl_o.win_issue   = (state_q == ST_WINDOW);
    ctl_o.centre_load = (state_q == ST_WINDOW) && (row_q == '0) && (col_q == '0);
    ctl_o.ofs_row     = row_q;
    ctl_o.ofs_col     = col_q;
    ctl_o.div_init    = (state_q == ST_DIV_INIT);
    ctl_o.div_step    = (state_q == ST_DIVIDE);
    ctl_o.div_bit     = bit_q;
    ctl_o.out_load    = (state_q == ST_FINISH) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      bit_q   <= bit_d;
    end
  end

endmodule

// ----- rtl/core/bif_dp.sv -----
`timescale 1ns / 1ps

module bif_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int RADIUS     = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_index_i,
  input  logic [bif_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       mode_i,
  input  logic [7:0]                 row_i,
  input  logic [7:0]                 col_i,
  input  logic [7:0]                 in_blue_i,
  input  logic [7:0]                 in_green_i,
  input  logic [7:0]                 in_red_i,
  input  logic [7:0]                 in_alpha_i,
  input  bif_pkg::ctl_t              ctl_i,
  output bif_pkg::sts_t              sts_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_blue_o,
  output logic [7:0]                 out_green_o,
  output logic [7:0]                 out_red_o,
  output logic [7:0]                 out_alpha_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int R2     = RADIUS * RADIUS;
  localparam int SP_N   = 2 * R2 + 1;
  localparam int SP_IW  = $clog2(SP_N);
  localparam int SP_DEN = 2 * R2;
  localparam int RG_DEN = 18 * R2;
  localparam int CW     = bif_pkg::CFG_W;

  typedef logic [15:0] sp_tab_t [SP_N];
  typedef logic [15:0] rg_tab_t [256];

  function automatic sp_tab_t build_spatial();
    sp_tab_t t;
    for (int d = 0; d < SP_N; d++) begin
      t[d] = bif_pkg::exp_weight((bif_pkg::u64_t'(d) * 9 * 65536 + R2) / SP_DEN);
    end
    return t;
  endfunction

  function automatic rg_tab_t build_range();
    rg_tab_t t;
    for (int d = 0; d < 256; d++) begin
      t[d] = bif_pkg::exp_weight((bif_pkg::u64_t'(d) * d * 65536 + 9 * R2) / RG_DEN);
    end
    return t;
  endfunction

  localparam sp_tab_t SPATIAL_W = build_spatial();
  localparam rg_tab_t RANGE_W   = build_range();
  localparam logic [bif_pkg::OFS_W-1:0] RAD_O = bif_pkg::OFS_W'(RADIUS);
  localparam logic signed [10:0]        RAD_S = 11'(RADIUS);

  // configuration registers and effective frame size
  logic [CW-1:0] width_q, height_q;
  logic [CW-1:0] eff_w, eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(256);
      height_q <= CW'(256);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bif_pkg::REG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = CW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = CW'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      eff_h = CW'(MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
  end

  // centre coordinates, clamped into the frame
  logic [7:0] crow_q, ccol_q;
  logic       in_frame;
  logic       wr_en;

  assign in_frame = ({1'b0, row_i} < eff_h) && ({1'b0, col_i} < eff_w);
  assign wr_en    = ctl_i.in_take && !mode_i && in_frame;

  always_ff @(posedge clk_i) begin
    if (ctl_i.in_take && mode_i) begin
      crow_q <= ({1'b0, row_i} >= eff_h) ? 8'(eff_h - 1'b1) : row_i;
      ccol_q <= ({1'b0, col_i} >= eff_w) ? 8'(eff_w - 1'b1) : col_i;
    end
  end

  // window coordinates with border clamp
  logic signed [10:0] sum_r, sum_c;
  logic [CW-1:0]      win_r, win_c;

  always_comb begin
    sum_r = $signed({3'b0, crow_q}) + $signed({6'b0, ctl_i.ofs_row}) - RAD_S;
    sum_c = $signed({3'b0, ccol_q}) + $signed({6'b0, ctl_i.ofs_col}) - RAD_S;
    if (sum_r < 0) begin
      win_r = '0;
    end else if (sum_r >= $signed({2'b0, eff_h})) begin
      win_r = eff_h - 1'b1;
    end else begin
      win_r = sum_r[CW-1:0];
    end
    if (sum_c < 0) begin
      win_c = '0;
    end else if (sum_c >= $signed({2'b0, eff_w})) begin
      win_c = eff_w - 1'b1;
    end else begin
      win_c = sum_c[CW-1:0];
    end
  end

  // single port address select
  logic [AW-1:0] addr;

  always_comb begin
    priority if (ctl_i.in_take) begin
      addr = AW'(int'(row_i) * MAX_WIDTH + int'(col_i));
    end else if (ctl_i.rd_centre) begin
      addr = AW'(int'(crow_q) * MAX_WIDTH + int'(ccol_q));
    end else begin
      addr = AW'(int'(win_r) * MAX_WIDTH + int'(win_c));
    end
  end

  // frame store
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr] <= {in_alpha_i, in_red_i, in_green_i, in_blue_i};
    end
    rd_q <= mem[addr];
  end

  // spatial weight lookup, aligned with the read data
  logic [bif_pkg::OFS_W-1:0] dr, dc;
  logic [10:0]               d2;
  logic [15:0]               sp_q;
  logic [31:0]               centre_q;

  always_comb begin
    dr = (ctl_i.ofs_row >= RAD_O) ? ctl_i.ofs_row - RAD_O : RAD_O - ctl_i.ofs_row;
    dc = (ctl_i.ofs_col >= RAD_O) ? ctl_i.ofs_col - RAD_O : RAD_O - ctl_i.ofs_col;
    d2 = (11'(dr) * 11'(dr)) + (11'(dc) * 11'(dc));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.win_issue) begin
      sp_q <= SPATIAL_W[d2[SP_IW-1:0]];
    end
    if (ctl_i.centre_load) begin
      centre_q <= rd_q;
    end
  end

  // weight pipeline, one lane per colour channel
  logic                      v1_q, v2_q, v3_q;
  logic [31:0]               wt_d   [3];
  logic [31:0]               wt_q   [3];
  logic [7:0]                val_q  [3];
  logic [39:0]               prod_q [3];
  logic [31:0]               wtc_q  [3];
  logic [bif_pkg::NUM_W-1:0] num_q  [3];
  logic [bif_pkg::DEN_W-1:0] den_q  [3];
  logic [bif_pkg::REM_W-1:0] rem_q  [3];
  logic [bif_pkg::REM_W-1:0] shf    [3];
  logic [7:0]                quo_q  [3];
  logic [7:0]                pv     [3];
  logic [7:0]                cv     [3];
  logic [7:0]                dif    [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pv[c]   = rd_q[8*c +: 8];
      cv[c]   = centre_q[8*c +: 8];
      dif[c]  = (pv[c] > cv[c]) ? pv[c] - cv[c] : cv[c] - pv[c];
      wt_d[c] = sp_q * RANGE_W[dif[c]];
      shf[c]  = bif_pkg::REM_W'(den_q[c]) << ctl_i.div_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.win_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // products, accumulation and bit-per-cycle division
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      wt_q[c]   <= wt_d[c];
      val_q[c]  <= pv[c];
      prod_q[c] <= wt_q[c] * val_q[c];
      wtc_q[c]  <= wt_q[c];
      if (ctl_i.acc_clear) begin
        num_q[c] <= '0;
        den_q[c] <= '0;
      end else if (v3_q) begin
        num_q[c] <= num_q[c] + bif_pkg::NUM_W'(prod_q[c]);
        den_q[c] <= den_q[c] + bif_pkg::DEN_W'(wtc_q[c]);
      end
      if (ctl_i.div_init) begin
        rem_q[c] <= bif_pkg::REM_W'(num_q[c]) + bif_pkg::REM_W'(den_q[c] >> 1);
        quo_q[c] <= '0;
      end else if (ctl_i.div_step) begin
        if (rem_q[c] >= shf[c]) begin
          rem_q[c] <= rem_q[c] - shf[c];
          quo_q[c] <= {quo_q[c][6:0], 1'b1};
        end else begin
          quo_q[c] <= {quo_q[c][6:0], 1'b0};
        end
      end
    end
  end

  // output register
  logic       out_valid_q;
  logic [7:0] ob_q, og_q, or_q, oa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      ob_q <= (den_q[0] == '0) ? 8'd0 : quo_q[0];
      og_q <= (den_q[1] == '0) ? 8'd0 : quo_q[1];
      or_q <= (den_q[2] == '0) ? 8'd0 : quo_q[2];
      oa_q <= centre_q[31:24];
    end
  end

  assign sts_o.pipe_busy = v1_q || v2_q || v3_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_blue_o      = ob_q;
  assign out_green_o     = og_q;
  assign out_red_o       = or_q;
  assign out_alpha_o     = oa_q;

endmodule

// ----- rtl/core/bilateral_image_filter_top.sv -----
`timescale 1ns / 1ps
// store item: no result; written to the frame store only when inside the frame
// compute item: the single-port frame store is read for the centre and then once per
// window pixel, the pipeline drains, then a bit-serial division yields eight quotient
// bits; one item at a time, input stalled until the result is loaded, and the next
// item can be taken while that result waits at the output
// reset: asynchronous active low, frame size registers go to 256, frame store undefined
`include "bilateral_image_filter_top_assert.svh"

module bilateral_image_filter_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int RADIUS     = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [bif_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic [7:0]                row_i,
  input  logic [7:0]                col_i,
  input  logic [7:0]                in_blue_i,
  input  logic [7:0]                in_green_i,
  input  logic [7:0]                in_red_i,
  input  logic [7:0]                in_alpha_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_blue_o,
  output logic [7:0]                out_green_o,
  output logic [7:0]                out_red_o,
  output logic [7:0]                out_alpha_o
);

  bif_pkg::ctl_t ctl;
  bif_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  bif_ctrl #(
    .RADIUS (RADIUS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // frame store and arithmetic
  bif_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .RADIUS     (RADIUS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (mode_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .in_blue_i   (in_blue_i),
    .in_green_i  (in_green_i),
    .in_red_i    (in_red_i),
    .in_alpha_i  (in_alpha_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_blue_o  (out_blue_o),
    .out_green_o (out_green_o),
    .out_red_o   (out_red_o),
    .out_alpha_o (out_alpha_o)
  );

  // checks
  `BIF_ASSERT_NOW(a_no_overwrite, ctl.out_load, !out_valid_o || !out_stall_i, "result overwritten")
  `BIF_ASSERT_NEXT(a_compute_busy, in_valid_i && !in_stall_o && mode_i, in_stall_o, "compute not held")
  `BIF_ASSERT_NOW(a_rise_from_load, $rose(out_valid_o), $past(ctl.out_load), "result without load")
  `BIF_ASSERT_NOW(a_issue_not_take, ctl.win_issue, !ctl.in_take, "take during window")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } bgra_t;

  // frame store model and filtered pixel predictor
  class filter_predictor;
    localparam int R = 8;
    localparam int MAXW = 256;
    localparam int MAXH = 256;

    logic [31:0]   pixel_mem [MAXW*MAXH];
    bit            written [MAXW*MAXH];
    logic [8:0]    width_reg;
    logic [8:0]    height_reg;
    logic [15:0]   spatial_lut [2*R*R+1];
    logic [15:0]   range_lut [256];
    bgra_t         pending_pixels [$];
    int            errors;

    function new();
      longint unsigned r2;
      r2 = R * R;
      width_reg = 9'd256;
      height_reg = 9'd256;
      errors = 0;
      for (int d = 0; d <= 2*R*R; d++) begin
        spatial_lut[d] = gauss_q16((9 * longint'(d) * 65536 + r2) / (2 * r2));
      end
      for (int d = 0; d < 256; d++) begin
        range_lut[d] = gauss_q16((longint'(d) * d * 65536 + 9 * r2) / (18 * r2));
      end
    endfunction

    // 65536*exp(-x), x in q16: integer table times series of the fraction
    function logic [15:0] gauss_q16(longint unsigned xq);
      longint unsigned n;
      longint unsigned f;
      longint unsigned term;
      longint unsigned w;
      longint          acc;
      n = xq >> 16;
      f = xq & 64'hFFFF;
      term = 64'd1 << 30;
      acc = 0;
      if (n >= 12) return 16'd0;
      for (int k = 0; k <= 12; k++) begin
        if (k % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
        term = (term * f) / (longint'(k + 1) << 16);
      end
      if (acc < 0) acc = 0;
      w = (longint'(acc) * longint'(bif_pkg::EXP_INT_Q30[n]) + (64'd1 << 43)) >> 44;
      if (w > 65535) w = 65535;
      return w[15:0];
    endfunction

    function int eff_size(logic [8:0] v, int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : int'(v);
    endfunction

    function int frame_w();
      return eff_size(width_reg, MAXW);
    endfunction

    function int frame_h();
      return eff_size(height_reg, MAXH);
    endfunction

    function void set_reg(logic idx, logic [8:0] v);
      if (idx == bif_pkg::REG_FRAME_WIDTH) width_reg = v;
      else height_reg = v;
    endfunction

    function int clampc(int c, int size);
      if (c < 0) return 0;
      if (c >= size) return size - 1;
      return c;
    endfunction

    // accepted input transaction: store pixel or predict the filtered one
    function void note_input(logic mode, logic [7:0] row, logic [7:0] col,
                             logic [31:0] bgra);
      int              w;
      int              h;
      int              rr;
      int              cc;
      logic [31:0]     centre;
      logic [31:0]     px;
      longint unsigned num [3];
      longint unsigned den [3];
      longint unsigned wt;
      longint unsigned q;
      int              v;
      int              c;
      int              dd;
      logic [7:0]      res [3];
      bgra_t           e;
      w = frame_w();
      h = frame_h();
      rr = row;
      cc = col;
      if (mode == 1'b0) begin
        if (rr < h && cc < w) begin
          pixel_mem[rr*MAXW+cc] = bgra;
          written[rr*MAXW+cc] = 1'b1;
        end
        return;
      end
      if (rr >= h) rr = h - 1;
      if (cc >= w) cc = w - 1;
      centre = pixel_mem[rr*MAXW+cc];
      for (int ch = 0; ch < 3; ch++) begin
        num[ch] = 0;
        den[ch] = 0;
      end
      for (int i = -R; i <= R; i++) begin
        for (int j = -R; j <= R; j++) begin
          px = pixel_mem[clampc(rr + i, h)*MAXW + clampc(cc + j, w)];
          for (int ch = 0; ch < 3; ch++) begin
            v = (px >> (8*ch)) & 8'hFF;
            c = (centre >> (8*ch)) & 8'hFF;
            dd = (v > c) ? v - c : c - v;
            wt = longint'(spatial_lut[i*i+j*j]) * longint'(range_lut[dd]);
            num[ch] += wt * v;
            den[ch] += wt;
          end
        end
      end
      for (int ch = 0; ch < 3; ch++) begin
        q = (den[ch] != 0) ? (num[ch] + den[ch] / 2) / den[ch] : 0;
        res[ch] = (q > 255) ? 8'd255 : q[7:0];
      end
      e.blue = res[0];
      e.green = res[1];
      e.red = res[2];
      e.alpha = centre[31:24];
      pending_pixels.push_back(e);
    endfunction

    task report(string field, logic [7:0] got, logic [7:0] exp_v);
      $display("mismatch on %s: got %0d, expected %0d", field, got, exp_v);
      errors++;
    endtask

    // accepted result transaction against the oldest prediction
    task check_pixel(bgra_t got);
      bgra_t e;
      if (pending_pixels.size() == 0) begin
        $display("result with no prediction waiting");
        errors++;
        return;
      end
      e = pending_pixels.pop_front();
      if (got.blue !== e.blue) report("blue", got.blue, e.blue);
      if (got.green !== e.green) report("green", got.green, e.green);
      if (got.red !== e.red) report("red", got.red, e.red);
      if (got.alpha !== e.alpha) report("alpha", got.alpha, e.alpha);
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [8:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       mode_i = 1'b0;
  logic [7:0] row_i = '0;
  logic [7:0] col_i = '0;
  logic [7:0] in_blue_i = '0;
  logic [7:0] in_green_i = '0;
  logic [7:0] in_red_i = '0;
  logic [7:0] in_alpha_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_blue_o;
  logic [7:0] out_green_o;
  logic [7:0] out_red_o;
  logic [7:0] out_alpha_o;

  filter_predictor pred;
  bit              idle_on = 1'b1;
  int              hold_left = 0;
  int              quiet_cycles = 0;

  bilateral_image_filter_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .mode_i(mode_i), .row_i(row_i), .col_i(col_i),
    .in_blue_i(in_blue_i), .in_green_i(in_green_i),
    .in_red_i(in_red_i), .in_alpha_i(in_alpha_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_blue_o(out_blue_o), .out_green_o(out_green_o),
    .out_red_o(out_red_o), .out_alpha_o(out_alpha_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 12);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    bgra_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.blue = out_blue_o;
      got.green = out_green_o;
      got.red = out_red_o;
      got.alpha = out_alpha_o;
      pred.check_pixel(got);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic idx, logic [8:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    pred.set_reg(idx, v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic mode, logic [7:0] row, logic [7:0] col,
                            logic [31:0] bgra);
    while (idle_on && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    row_i <= row;
    col_i <= col;
    {in_alpha_i, in_red_i, in_green_i, in_blue_i} <= bgra;
    do @(posedge clk_i); while (in_stall_o);
    pred.note_input(mode, row, col, bgra);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pred.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // one frame size: configure, fill unwritten pixels, then random traffic
  task automatic run_phase(logic [8:0] w_reg, logic [8:0] h_reg, int n_rand);
    int w;
    int h;
    write_reg(bif_pkg::REG_FRAME_WIDTH, w_reg);
    write_reg(bif_pkg::REG_FRAME_HEIGHT, h_reg);
    w = pred.frame_w();
    h = pred.frame_h();
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (!pred.written[r*256+c]) send_pixel(1'b0, 8'(r), 8'(c), $urandom);
      end
    end
    for (int n = 0; n < n_rand; n++) begin
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(1)) send_pixel(1'b1, 8'($urandom_range(h-1)),
                                          8'($urandom_range(w-1)), $urandom);
        else send_pixel(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        $urandom);
      end else begin
        if ($urandom_range(1)) send_pixel(1'b0, 8'($urandom_range(h-1)),
                                          8'($urandom_range(w-1)), $urandom);
        else send_pixel(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        $urandom);
      end
    end
    wait_drained();
  endtask

  initial begin
    pred = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single pixel frame: extreme values, clamped and ignored coordinates
    write_reg(bif_pkg::REG_FRAME_WIDTH, 9'd0);
    write_reg(bif_pkg::REG_FRAME_HEIGHT, 9'd0);
    send_pixel(1'b0, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_pixel(1'b1, 8'd0, 8'd0, 32'h0);
    send_pixel(1'b1, 8'd255, 8'd255, 32'h0);
    send_pixel(1'b0, 8'd1, 8'd0, 32'h0);
    send_pixel(1'b0, 8'd0, 8'd255, 32'h0);
    send_pixel(1'b1, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_pixel(1'b0, 8'd0, 8'd0, 32'h0);
    send_pixel(1'b1, 8'd128, 8'd7, 32'h0);
    send_pixel(1'b0, 8'd0, 8'd0, 32'h80FF_00FF);
    send_pixel(1'b1, 8'd0, 8'd0, 32'h0);
    wait_drained();

    run_phase(9'd256, 9'd1, 120);
    run_phase(9'd1, 9'd256, 40);
    // long receiver hold-off so the block backs up onto its input
    hold_left = 2000;
    run_phase(9'd1, 9'd256, 80);
    idle_on = 1'b0;
    run_phase(9'd511, 9'd2, 150);
    idle_on = 1'b1;
    run_phase(9'd5, 9'd7, 150);
    // height register above the maximum on an already filled column
    run_phase(9'd1, 9'd300, 110);

    if (pred.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
